### src/cmrg_pkg.sv
// Shared constants, payload types and modular-reduction helpers for the
// combined multiple recursive generator. No dependencies.
package cmrg_pkg;

	localparam logic [30:0] MOD_ONE = 31'd2147483647;
	localparam logic [30:0] MOD_TWO = 31'd2145483479;
	// 2^31 mod MOD_TWO, used to fold the upper part of a product back in
	localparam logic [20:0] FOLD_TWO = 21'd2000169;

	localparam logic [15:0] MUL_ONE_LAG2 = 16'd63308;
	localparam logic [17:0] MUL_ONE_LAG3 = 18'd183326;
	localparam logic [16:0] MUL_TWO_LAG1 = 17'd86098;
	localparam logic [19:0] MUL_TWO_LAG3 = 20'd539608;

	localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
	localparam int PROD_W = 51;

	// Seeds, oldest first
	localparam logic [30:0] SEED_ONE_0 = 31'd12345;
	localparam logic [30:0] SEED_ONE_1 = 31'd67890;
	localparam logic [30:0] SEED_ONE_2 = 31'd13579;
	localparam logic [30:0] SEED_TWO_0 = 31'd24680;
	localparam logic [30:0] SEED_TWO_1 = 31'd98765;
	localparam logic [30:0] SEED_TWO_2 = 31'd43210;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic signed [31:0] lower_bound;
		logic signed [31:0] upper_bound;
	} cmrg_req_t;

	typedef struct packed {
		logic signed [31:0] bounded_value;
		logic        [31:0] unit_fraction;
		logic               range_error;
	} cmrg_rsp_t;

	// Classified request as held in the queue
	typedef struct packed {
		logic signed [31:0] lower_bound;
		logic signed [31:0] upper_bound;
		logic        [32:0] span;
		logic               range_error;
	} cmrg_job_t;

	// p mod (2^31-1), first step: high part plus low part
	function automatic logic [31:0] fold_one(input logic [PROD_W-1:0] p);
		return 32'(p[PROD_W-1:31]) + 32'(p[30:0]);
	endfunction

	function automatic logic [30:0] reduce_one(input logic [31:0] r);
		logic [31:0] d;
		d = r;
		if (r >= {1'b0, MOD_ONE})
			d = r - {1'b0, MOD_ONE};
		return d[30:0];
	endfunction

	function automatic logic [41:0] fold_two(input logic [PROD_W-1:0] p);
		logic [40:0] hm;
		hm = 41'(p[PROD_W-1:31]) * 41'(FOLD_TWO);
		return 42'(hm) + 42'(p[30:0]);
	endfunction

	function automatic logic [32:0] fold_two_hi(input logic [41:0] t);
		logic [31:0] hm;
		hm = 32'(t[41:31]) * 32'(FOLD_TWO);
		return 33'(hm) + 33'(t[30:0]);
	endfunction

	// Value stays below three times the modulus
	function automatic logic [30:0] reduce_two(input logic [32:0] u);
		logic [32:0] d;
		d = u;
		if (u >= {1'b0, MOD_TWO, 1'b0})
			d = u - {1'b0, MOD_TWO, 1'b0};
		else if (u >= {2'b0, MOD_TWO})
			d = u - {2'b0, MOD_TWO};
		return d[30:0];
	endfunction

	// (a - b) mod m with a, b below m
	function automatic logic [30:0] sub_mod(input logic [30:0] a, input logic [30:0] b,
		input logic [30:0] m);
		logic [31:0] d;
		if (a >= b)
			d = {1'b0, a} - {1'b0, b};
		else
			d = {1'b0, a} + {1'b0, m} - {1'b0, b};
		return d[30:0];
	endfunction

endpackage

### src/combined_mrg_uniform_integer.sv
// Combined multiple recursive uniform integer generator, top level.
// Depends on cmrg_pkg, cmrg_front, cmrg_fifo, cmrg_gen, cmrg_back.
//
//   channel | dir | handshake          | payload
//   req     | in  | req_valid/req_stall | cmrg_req_t: lower_bound, upper_bound
//   rsp     | out | rsp_valid/rsp_stall | cmrg_rsp_t: bounded_value, unit_fraction,
//           |     |                     |             range_error
//
// Throughput is set by the six-step modular recurrence in cmrg_gen; it computes
// the next fraction ahead of demand. With a fraction ready, a request passes
// through the queue, the s1 and s2 stages and the output register to rsp.
// Reset loads the seed histories; the first fraction follows the six steps.
// Requests keep being taken into a two-entry queue while rsp stalls, until full.
module combined_mrg_uniform_integer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  cmrg_pkg::cmrg_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output cmrg_pkg::cmrg_rsp_t rsp
);
	import cmrg_pkg::*;

	logic        q_full, q_push, q_pop, q_vld;
	cmrg_job_t   push_job, pop_job;
	logic        frac_vld, frac_take;
	logic [31:0] frac;

	cmrg_front u_front (
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (push_job)
	);

	cmrg_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.vld      (q_vld),
		.pop_job  (pop_job)
	);

	cmrg_gen u_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.frac_take (frac_take),
		.frac_vld  (frac_vld),
		.frac      (frac)
	);

	cmrg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_vld     (q_vld),
		.q_job     (pop_job),
		.q_pop     (q_pop),
		.frac_vld  (frac_vld),
		.frac      (frac),
		.frac_take (frac_take),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

### src/cmrg_fifo.sv
// Short queue of classified requests between front and back.
// Depends on cmrg_pkg.
module cmrg_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cmrg_pkg::cmrg_job_t push_job,
	output logic              full,
	input  logic              pop,
	output logic              vld,
	output cmrg_pkg::cmrg_job_t pop_job
);
	import cmrg_pkg::*;

	cmrg_job_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;

	assign full    = (cnt_q == QCNT_W'(QDEPTH));
	assign vld     = (cnt_q != '0);
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> vld)
		else $error("queue pop while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count out of range");
`endif

endmodule

### src/cmrg_front.sv
// Request front end: takes a request, checks the bounds and forms the span.
// Depends on cmrg_pkg.
module cmrg_front (
	input  logic                req_valid,
	output logic                req_stall,
	input  cmrg_pkg::cmrg_req_t req,
	input  logic                q_full,
	output logic                q_push,
	output cmrg_pkg::cmrg_job_t q_job
);
	import cmrg_pkg::*;

	logic signed [33:0] diff;

	assign req_stall = q_full;
	assign q_push    = req_valid && !q_full;

	// upper - lower in 34 bits; negative means reversed bounds
	assign diff = $signed({{2{req.upper_bound[31]}}, req.upper_bound})
		- $signed({{2{req.lower_bound[31]}}, req.lower_bound});

	always_comb begin
		q_job.lower_bound = req.lower_bound;
		q_job.upper_bound = req.upper_bound;
		q_job.span        = diff[32:0] + 33'd1;
		q_job.range_error = diff[33];
	end

endmodule

### src/cmrg_gen.sv
// Two order-3 recurrences and their combination into a Q1.31 fraction.
// Runs one fraction ahead of demand. Depends on cmrg_pkg.
module cmrg_gen (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        frac_take,
	output logic        frac_vld,
	output logic [31:0] frac
);
	import cmrg_pkg::*;

	typedef enum logic [2:0] {
		ST_MUL, ST_FOLD_A, ST_FOLD_B, ST_REDUCE, ST_DIFF, ST_COMBINE
	} gen_state_t;

	gen_state_t         state_q;
	logic [30:0]        fh_q [3];
	logic [30:0]        sh_q [3];
	logic [PROD_W-1:0]  pa1_q, pb1_q, pa2_q, pb2_q;
	logic [31:0]        ra1_q, rb1_q;
	logic [41:0]        ta2_q, tb2_q;
	logic [30:0]        a1_q, b1_q, a2_q, b2_q;
	logic [32:0]        ua2_q, ub2_q;
	logic [30:0]        h;
	logic               frac_vld_q;
	logic [31:0]        frac_q;
	logic               slot_free;

	assign frac_vld  = frac_vld_q;
	assign frac      = frac_q;
	assign slot_free = !frac_vld_q || frac_take;
	assign h         = sub_mod(fh_q[2], sh_q[2], MOD_ONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_MUL;
			fh_q[0]    <= SEED_ONE_0;
			fh_q[1]    <= SEED_ONE_1;
			fh_q[2]    <= SEED_ONE_2;
			sh_q[0]    <= SEED_TWO_0;
			sh_q[1]    <= SEED_TWO_1;
			sh_q[2]    <= SEED_TWO_2;
			frac_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_MUL: begin
					pa1_q   <= PROD_W'(MUL_ONE_LAG2) * PROD_W'(fh_q[1]);
					pb1_q   <= PROD_W'(MUL_ONE_LAG3) * PROD_W'(fh_q[0]);
					pa2_q   <= PROD_W'(MUL_TWO_LAG1) * PROD_W'(sh_q[2]);
					pb2_q   <= PROD_W'(MUL_TWO_LAG3) * PROD_W'(sh_q[0]);
					state_q <= ST_FOLD_A;
				end
				ST_FOLD_A: begin
					ra1_q   <= fold_one(pa1_q);
					rb1_q   <= fold_one(pb1_q);
					ta2_q   <= fold_two(pa2_q);
					tb2_q   <= fold_two(pb2_q);
					state_q <= ST_FOLD_B;
				end
				ST_FOLD_B: begin
					a1_q    <= reduce_one(ra1_q);
					b1_q    <= reduce_one(rb1_q);
					ua2_q   <= fold_two_hi(ta2_q);
					ub2_q   <= fold_two_hi(tb2_q);
					state_q <= ST_REDUCE;
				end
				ST_REDUCE: begin
					a2_q    <= reduce_two(ua2_q);
					b2_q    <= reduce_two(ub2_q);
					fh_q[0] <= fh_q[1];
					fh_q[1] <= fh_q[2];
					fh_q[2] <= sub_mod(a1_q, b1_q, MOD_ONE);
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					sh_q[0] <= sh_q[1];
					sh_q[1] <= sh_q[2];
					sh_q[2] <= sub_mod(a2_q, b2_q, MOD_TWO);
					state_q <= ST_COMBINE;
				end
				ST_COMBINE: begin
					// hold here until the previous fraction has been taken
					if (slot_free) begin
						frac_q     <= (h == '0) ? ONE_Q31 : {1'b0, h};
						state_q    <= ST_MUL;
					end
				end
				default: state_q <= ST_MUL;
			endcase
			// a new fraction replaces one taken in the same cycle
			if (state_q == ST_COMBINE && slot_free)
				frac_vld_q <= 1'b1;
			else if (frac_take)
				frac_vld_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_first_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		fh_q[0] < MOD_ONE && fh_q[1] < MOD_ONE && fh_q[2] < MOD_ONE)
		else $error("first history out of range");
	a_second_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		sh_q[0] < MOD_TWO && sh_q[1] < MOD_TWO && sh_q[2] < MOD_TWO)
		else $error("second history out of range");
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		frac_vld_q |-> (frac_q != '0 && frac_q <= ONE_Q31))
		else $error("fraction out of range");
`endif

endmodule

### src/cmrg_back.sv
// Back end: pairs a queued request with the next fraction, scales the span
// by it and holds the result for the output. Depends on cmrg_pkg.
module cmrg_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_vld,
	input  cmrg_pkg::cmrg_job_t q_job,
	output logic                q_pop,
	input  logic                frac_vld,
	input  logic [31:0]         frac,
	output logic                frac_take,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output cmrg_pkg::cmrg_rsp_t rsp
);
	import cmrg_pkg::*;

	logic        en;
	logic        load;
	logic        v_s1, v_s2;
	cmrg_job_t   job_s1, job_s2;
	logic [31:0] frac_s1, frac_s2;
	logic [48:0] pl_s1, ph_s1;
	logic [31:0] off_s2;
	logic [64:0] prod;
	logic        rsp_vld_q;
	cmrg_rsp_t   rsp_q;

	assign en        = !(rsp_vld_q && rsp_stall);
	assign load      = en && q_vld && frac_vld;
	assign q_pop     = load;
	assign frac_take = load;
	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	// span * frac from two 16-bit halves of the fraction
	assign prod = {ph_s1, 16'b0} + 65'(pl_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			job_s1  <= q_job;
			frac_s1 <= frac;
			pl_s1   <= 49'(q_job.span) * 49'(frac[15:0]);
			ph_s1   <= 49'(q_job.span) * 49'(frac[31:16]);
			job_s2  <= job_s1;
			frac_s2 <= frac_s1;
			off_s2  <= prod[62:31];
			rsp_q.unit_fraction <= frac_s2;
			rsp_q.range_error   <= job_s2.range_error;
			// a fraction of one would land on upper+1, so it yields upper
			if (job_s2.range_error)
				rsp_q.bounded_value <= job_s2.lower_bound;
			else if (frac_s2 == ONE_Q31)
				rsp_q.bounded_value <= job_s2.upper_bound;
			else
				rsp_q.bounded_value <= job_s2.lower_bound + $signed(off_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else if (en) begin
			v_s1      <= load;
			v_s2      <= v_s1;
			rsp_vld_q <= v_s2;
		end
	end

`ifndef SYNTHESIS
	a_take_needs_frac: assert property (@(posedge clk) disable iff (!arst_n)
		frac_take |-> (frac_vld && q_vld))
		else $error("fraction taken without a pending request");
	a_out_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_q |-> (rsp_q.unit_fraction != '0 && rsp_q.unit_fraction <= ONE_Q31))
		else $error("result fraction out of range");
	a_error_gives_lower: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && en && job_s2.range_error)
		|=> (rsp_q.bounded_value == $past(job_s2.lower_bound)))
		else $error("reversed bounds did not return the lower bound");
`endif

endmodule
